FILE: src/erm_pkg.sv
// erm_pkg: shared types and codes for the event routing matrix
// opcode and register-index codes, request and response payload structs
// no dependencies
`default_nettype none

package erm_pkg;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_EVENT = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_STROBE_ADDR  = 2'd0,
      CSR_CHANNEL_BASE = 2'd1,
      CSR_USER_BASE    = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   localparam int unsigned ADDR_W    = 16;
   localparam int unsigned DATA_W    = 8;
   localparam int unsigned SHOW_CHAN = 8;
   localparam int unsigned SHOW_USER = 16;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ADDR_W-1:0] bus_addr;
      logic [DATA_W-1:0] write_data;
      logic [7:0]        generator;
      logic              event_level;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]    read_data;
      logic [SHOW_USER-1:0] notify_mask;
      logic                 notify_level;
      logic                 notify_pulse;
      logic [SHOW_CHAN-1:0] channel_levels;
      logic [SHOW_USER-1:0] user_levels;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/erm_if.sv
// erm_req_if / erm_rsp_if: valid-ready channels of the event routing matrix
// request channel carries bus accesses and events, response channel the results
`default_nettype none

interface erm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] bus_addr;
   logic [7:0]  write_data;
   logic [7:0]  generator;
   logic        event_level;

   modport source (output valid, output opcode, output bus_addr, output write_data,
                   output generator, output event_level, input ready);
   modport sink   (input valid, input opcode, input bus_addr, input write_data,
                   input generator, input event_level, output ready);
endinterface

interface erm_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [15:0] notify_mask;
   logic        notify_level;
   logic        notify_pulse;
   logic [7:0]  channel_levels;
   logic [15:0] user_levels;

   modport source (output valid, output read_data, output notify_mask, output notify_level,
                   output notify_pulse, output channel_levels, output user_levels,
                   input ready);
   modport sink   (input valid, input read_data, input notify_mask, input notify_level,
                   input notify_pulse, input channel_levels, input user_levels,
                   output ready);
endinterface

`default_nettype wire

FILE: src/event_routing_matrix_core.sv
// event_routing_matrix_core: top level of the event routing matrix
// request register, erm_datapath, response register and address registers
// depends on erm_pkg, erm_if.sv and erm_datapath
//
// usage:
//   req_chan carries one request per handshake: a register read, a register
//   write or a generator event. rsp_chan returns exactly one response per
//   request, in order, with read data, the users notified and the channel and
//   user levels after the request has taken effect.
//   the csr_ port sets the strobe address and the two window base addresses;
//   write it only while no request is in flight.
//   path: an accepted request is held in the request register, evaluated
//   combinationally, and its response is captured in the response register.
//   throughput: one request per cycle; the request register and the response
//   register form a two-deep pipeline around a single combinational pass.
//   a stalled response holds its register; the request register keeps taking
//   one more request, after which req_chan.ready drops until rsp_chan moves.
//   reset: synchronous, clears every select, the strobe register, all channel
//   levels and the address registers, and empties both pipeline registers.
`default_nettype none

module event_routing_matrix_core
   import erm_pkg::*;
#(
   parameter int NUM_CHANNELS = 8,
   parameter int NUM_USERS    = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   erm_req_if.sink                req_chan,
   erm_rsp_if.source              rsp_chan,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [ADDR_W-1:0] csr_wdata
);

   logic [ADDR_W-1:0] strobe_addr_ff, channel_base_ff, user_base_ff;
   logic              req_vld_ff, req_vld_in;
   req_type           req_item_ff, req_item_in;
   logic              rsp_vld_ff, rsp_vld_in;
   rsp_type           rsp_item_ff, rsp_item_in;
   logic              out_ready, step;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_addr_ff  <= '0;
         channel_base_ff <= '0;
         user_base_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STROBE_ADDR:  strobe_addr_ff  <= csr_wdata;
            CSR_CHANNEL_BASE: channel_base_ff <= csr_wdata;
            CSR_USER_BASE:    user_base_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_ready      = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = !req_vld_ff || out_ready;
   assign step           = req_vld_ff && out_ready;

   assign req_vld_in = req_chan.ready ? req_chan.valid : req_vld_ff;
   assign rsp_vld_in = out_ready ? req_vld_ff : rsp_vld_ff;

   always_comb begin
      req_item_in.opcode      = req_chan.opcode;
      req_item_in.bus_addr    = req_chan.bus_addr;
      req_item_in.write_data  = req_chan.write_data;
      req_item_in.generator   = req_chan.generator;
      req_item_in.event_level = req_chan.event_level;
   end

   erm_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .NUM_USERS    (NUM_USERS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .req_item     (req_item_ff),
      .strobe_addr  (strobe_addr_ff),
      .channel_base (channel_base_ff),
      .user_base    (user_base_ff),
      .rsp_item     (rsp_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_item_ff <= req_item_in;
      end
      if (step) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.read_data      = rsp_item_ff.read_data;
   assign rsp_chan.notify_mask    = rsp_item_ff.notify_mask;
   assign rsp_chan.notify_level   = rsp_item_ff.notify_level;
   assign rsp_chan.notify_pulse   = rsp_item_ff.notify_pulse;
   assign rsp_chan.channel_levels = rsp_item_ff.channel_levels;
   assign rsp_chan.user_levels    = rsp_item_ff.user_levels;

`ifndef SYNTHESIS
   // both pipeline registers come out of reset empty
   assert property (@(posedge clock)
      reset |=> !rsp_vld_ff && !req_vld_ff)
      else $error("pipeline not empty after reset");

   // request side only stalls when both stages hold a request
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> req_vld_ff && rsp_vld_ff && !rsp_chan.ready)
      else $error("request stall without a full pipeline");

   // a notification flag needs at least one notified user
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_item_ff.notify_mask == '0 |->
         !rsp_item_ff.notify_pulse && !rsp_item_ff.notify_level)
      else $error("notification flag with empty mask");

   // a stalled request in the first stage moves on as soon as the response leaves
   assert property (@(posedge clock) disable iff (reset)
      req_vld_ff && rsp_vld_ff && rsp_chan.ready |=> rsp_vld_ff)
      else $error("request lost between stages");
`endif

endmodule

`default_nettype wire

FILE: src/erm_datapath.sv
// erm_datapath: routing register file and single-pass request evaluation
// holds strobe, channel selects, user selects and channel levels; uses erm_pkg
`default_nettype none

module erm_datapath
   import erm_pkg::*;
#(
   parameter int NUM_CHANNELS = 8,
   parameter int NUM_USERS    = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire req_type           req_item,
   input  wire logic [ADDR_W-1:0] strobe_addr,
   input  wire logic [ADDR_W-1:0] channel_base,
   input  wire logic [ADDR_W-1:0] user_base,
   output rsp_type                rsp_item
);

   localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int UW    = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
   localparam int SHOWN = (NUM_USERS < SHOW_USER) ? NUM_USERS : SHOW_USER;

   logic [DATA_W-1:0]                    strobe_ff, strobe_in;
   logic [NUM_CHANNELS-1:0][DATA_W-1:0]  gen_sel_ff, gen_sel_in;
   logic [NUM_USERS-1:0][DATA_W-1:0]     user_sel_ff, user_sel_in;
   logic [NUM_CHANNELS-1:0]              level_ff, level_in;

   logic                    strobe_match, chan_win, user_win;
   logic [ADDR_W-1:0]       chan_off, user_off;
   logic [NUM_CHANNELS-1:0] chan_hit;
   logic                    strobe_wr, event_go;

   // windows are compared in 17 bits so they never wrap past the top address
   assign strobe_match = (req_item.bus_addr == strobe_addr);
   assign chan_win = ({1'b0, req_item.bus_addr} >= {1'b0, channel_base}) &&
                     ({1'b0, req_item.bus_addr} <
                      ({1'b0, channel_base} + (ADDR_W+1)'(NUM_CHANNELS)));
   assign user_win = ({1'b0, req_item.bus_addr} >= {1'b0, user_base}) &&
                     ({1'b0, req_item.bus_addr} <
                      ({1'b0, user_base} + (ADDR_W+1)'(NUM_USERS)));
   assign chan_off = req_item.bus_addr - channel_base;
   assign user_off = req_item.bus_addr - user_base;

   always_comb begin
      strobe_in   = strobe_ff;
      gen_sel_in  = gen_sel_ff;
      user_sel_in = user_sel_ff;
      level_in    = level_ff;
      chan_hit    = '0;
      strobe_wr   = 1'b0;
      event_go    = 1'b0;
      rsp_item    = '0;

      case (opcode_type'(req_item.opcode))
         OP_READ: begin
            if (strobe_match) begin
               rsp_item.read_data = strobe_ff;
            end else if (chan_win) begin
               rsp_item.read_data = gen_sel_ff[chan_off[CW-1:0]];
            end else if (user_win) begin
               rsp_item.read_data = user_sel_ff[user_off[UW-1:0]];
            end
         end
         OP_WRITE: begin
            if (strobe_match) begin
               strobe_in = req_item.write_data;
               strobe_wr = 1'b1;
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  chan_hit[c] = req_item.write_data[c];
               end
            end else if (chan_win) begin
               gen_sel_in[chan_off[CW-1:0]] = req_item.write_data;
            end else if (user_win) begin
               user_sel_in[user_off[UW-1:0]] = req_item.write_data;
            end
         end
         OP_EVENT: begin
            if (req_item.generator != '0) begin
               event_go = 1'b1;
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  if (gen_sel_ff[c] == req_item.generator) begin
                     chan_hit[c] = 1'b1;
                     level_in[c] = req_item.event_level;
                  end
               end
            end
         end
         default: ;
      endcase

      // user selects are 1-based, so user u follows channel c when its select is c+1
      for (int u = 0; u < SHOWN; u++) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (user_sel_ff[u] == DATA_W'(c + 1) && chan_hit[c]) begin
               rsp_item.notify_mask[u] = 1'b1;
            end
            if (user_sel_in[u] == DATA_W'(c + 1) && level_in[c]) begin
               rsp_item.user_levels[u] = 1'b1;
            end
         end
      end

      rsp_item.notify_pulse = strobe_wr && (rsp_item.notify_mask != '0);
      rsp_item.notify_level = event_go && (rsp_item.notify_mask != '0) &&
                              req_item.event_level;
      rsp_item.channel_levels[NUM_CHANNELS-1:0] = level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff   <= '0;
         gen_sel_ff  <= '0;
         user_sel_ff <= '0;
         level_ff    <= '0;
      end else if (step) begin
         strobe_ff   <= strobe_in;
         gen_sel_ff  <= gen_sel_in;
         user_sel_ff <= user_sel_in;
         level_ff    <= level_in;
      end
   end

`ifndef SYNTHESIS
   // a strobe pulse never changes a channel level
   assert property (@(posedge clock) disable iff (reset)
      step && strobe_wr |-> level_in == level_ff)
      else $error("strobe write changed channel levels");

   // an idle cycle leaves the channel levels and the strobe register untouched
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(level_ff) && $stable(strobe_ff))
      else $error("state changed without a request");

   // pulse and event notification are exclusive
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_item.notify_pulse && rsp_item.notify_level))
      else $error("pulse and level notification at once");
`endif

endmodule

`default_nettype wire

FILE: tb/erm_route_checker.sv
// erm_route_checker: watches the request, response and csr ports of the event routing matrix,
// predicts every response from its own copy of the router state and compares field by field
// depends on erm_pkg and the channel interfaces in erm_if.sv

module erm_route_checker
   import erm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   erm_req_if               req_mon,
   erm_rsp_if               rsp_mon,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               fail_count,
   output int               outstanding
);

   localparam int CHANNELS = 8;
   localparam int USERS    = 16;

   // address decode registers
   logic [15:0] strobe_at;
   logic [15:0] chan_base;
   logic [15:0] user_base;

   // router state
   logic [7:0] strobe_q;
   logic [7:0] chan_gen [CHANNELS];
   logic [7:0] user_sel [USERS];
   logic [7:0] chan_lvl;

   rsp_type pending_results[$];
   int      results_seen;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch on %0s at response %0d: got %0h, expected %0h",
               what, results_seen, got, want);
      fail_count++;
   endtask

   // windows are compared without wrap past the top of the address space
   function automatic bit in_window(logic [15:0] a, logic [15:0] base, int count);
      return int'(a) >= int'(base) && int'(a) < int'(base) + count;
   endfunction

   // users whose selected channel is set in chans
   function automatic logic [15:0] users_on(logic [7:0] chans);
      logic [15:0] m;
      m = '0;
      for (int u = 0; u < USERS; u++) begin
         if (user_sel[u] >= 1 && user_sel[u] <= CHANNELS && chans[user_sel[u] - 1])
            m[u] = 1'b1;
      end
      return m;
   endfunction

   // applies one request to the router state and returns the response it produces
   function automatic rsp_type apply_request(req_type r);
      rsp_type     o;
      logic [7:0]  hit;
      int          ci;
      int          ui;
      o = '0;
      hit = '0;
      ci = int'(r.bus_addr) - int'(chan_base);
      ui = int'(r.bus_addr) - int'(user_base);
      case (opcode_type'(r.opcode))
         OP_READ: begin
            if (r.bus_addr == strobe_at)
               o.read_data = strobe_q;
            else if (in_window(r.bus_addr, chan_base, CHANNELS))
               o.read_data = chan_gen[ci];
            else if (in_window(r.bus_addr, user_base, USERS))
               o.read_data = user_sel[ui];
         end
         OP_WRITE: begin
            if (r.bus_addr == strobe_at) begin
               strobe_q = r.write_data;
               o.notify_mask = users_on(r.write_data);
               o.notify_pulse = |o.notify_mask;
            end else if (in_window(r.bus_addr, chan_base, CHANNELS)) begin
               chan_gen[ci] = r.write_data;
            end else if (in_window(r.bus_addr, user_base, USERS)) begin
               user_sel[ui] = r.write_data;
            end
         end
         OP_EVENT: begin
            if (r.generator != 8'd0) begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (chan_gen[c] == r.generator) begin
                     hit[c] = 1'b1;
                     chan_lvl[c] = r.event_level;
                  end
               end
               o.notify_mask = users_on(hit);
               o.notify_level = (|o.notify_mask) ? r.event_level : 1'b0;
            end
         end
         default: ;
      endcase
      o.channel_levels = chan_lvl;
      o.user_levels = users_on(chan_lvl);
      return o;
   endfunction

   always @(posedge clock) begin
      req_type r;
      rsp_type want;
      if (reset) begin
         strobe_at = '0;
         chan_base = '0;
         user_base = '0;
         strobe_q = '0;
         chan_lvl = '0;
         for (int c = 0; c < CHANNELS; c++) chan_gen[c] = '0;
         for (int u = 0; u < USERS; u++) user_sel[u] = '0;
         pending_results.delete();
         results_seen = 0;
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_STROBE_ADDR:  strobe_at = csr_wdata;
               CSR_CHANNEL_BASE: chan_base = csr_wdata;
               CSR_USER_BASE:    user_base = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected response", 0, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_mon.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_mon.read_data, want.read_data);
               if (rsp_mon.notify_mask !== want.notify_mask)
                  report_mismatch("notify_mask", rsp_mon.notify_mask, want.notify_mask);
               if (rsp_mon.notify_level !== want.notify_level)
                  report_mismatch("notify_level", rsp_mon.notify_level, want.notify_level);
               if (rsp_mon.notify_pulse !== want.notify_pulse)
                  report_mismatch("notify_pulse", rsp_mon.notify_pulse, want.notify_pulse);
               if (rsp_mon.channel_levels !== want.channel_levels)
                  report_mismatch("channel_levels", rsp_mon.channel_levels,
                                  want.channel_levels);
               if (rsp_mon.user_levels !== want.user_levels)
                  report_mismatch("user_levels", rsp_mon.user_levels, want.user_levels);
            end
            results_seen++;
         end
         if (req_mon.valid && req_mon.ready) begin
            r.opcode = req_mon.opcode;
            r.bus_addr = req_mon.bus_addr;
            r.write_data = req_mon.write_data;
            r.generator = req_mon.generator;
            r.event_level = req_mon.event_level;
            pending_results.insert(pending_results.size(), apply_request(r));
         end
         outstanding <= pending_results.size();
      end
   end

endmodule

FILE: tb/tb_event_routing_matrix_core.sv
// tb_event_routing_matrix_core: stimulus and verdict for event_routing_matrix_core
// drives requests, response back-pressure and csr writes; checking lives in erm_route_checker
// depends on erm_pkg, erm_if.sv, event_routing_matrix_core and erm_route_checker

module tb_event_routing_matrix_core;
   import erm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   erm_req_if req_chan();
   erm_rsp_if rsp_chan();

   int fail_count;
   int outstanding;
   int cycle_count;
   int send_idle_pct;
   int rsp_idle_pct;
   bit hold_rsp;

   logic [15:0] cfg_strobe;
   logic [15:0] cfg_chan;
   logic [15:0] cfg_user;

   event_routing_matrix_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   erm_route_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** event_routing_matrix_core: FAILED **");
      $finish;
   end

   // response back-pressure, with a long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic req_type mk_req(opcode_type op, logic [15:0] a, logic [7:0] d,
                                      logic [7:0] g, logic l);
      req_type r;
      r.opcode = op;
      r.bus_addr = a;
      r.write_data = d;
      r.generator = g;
      r.event_level = l;
      return r;
   endfunction

   // mostly accesses that land in or next to the live windows, with small select values
   // so that events and strobes actually reach users
   function automatic req_type random_request();
      req_type r;
      int      k;
      r.bus_addr = 16'($urandom);
      r.write_data = 8'($urandom);
      r.generator = 8'($urandom);
      r.event_level = 1'($urandom);
      k = $urandom_range(99);
      if (k < 15)
         r.bus_addr = cfg_strobe;
      else if (k < 45)
         r.bus_addr = 16'(cfg_chan + $urandom_range(0, 9));
      else if (k < 80)
         r.bus_addr = 16'(cfg_user + $urandom_range(0, 17));
      else if (k < 90)
         r.bus_addr = ($urandom_range(1)) ? 16'(cfg_chan - 1) : 16'(cfg_user - 1);
      k = $urandom_range(99);
      if (k < 50)
         r.write_data = 8'($urandom_range(0, 9));
      else if (k < 75)
         r.write_data = 8'($urandom_range(1, 6));
      if ($urandom_range(99) < 85)
         r.generator = 8'($urandom_range(0, 6));
      k = $urandom_range(99);
      if (k < 22)
         r.opcode = OP_READ;
      else if (k < 62)
         r.opcode = OP_WRITE;
      else if (k < 95)
         r.opcode = OP_EVENT;
      else
         r.opcode = OP_NOP;
      return r;
   endfunction

   // returns at the edge where the request was taken, valid still high
   task automatic push_request(input req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= r.opcode;
      req_chan.bus_addr <= r.bus_addr;
      req_chan.write_data <= r.write_data;
      req_chan.generator <= r.generator;
      req_chan.event_level <= r.event_level;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic push_random(input int count);
      for (int i = 0; i < count; i++) push_request(random_request());
   endtask

   // called right after an accepted request; waits for every response
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_windows(input logic [15:0] s, input logic [15:0] c,
                                  input logic [15:0] u);
      csr_we <= 1'b1;
      csr_index <= CSR_STROBE_ADDR;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= CSR_CHANNEL_BASE;
      csr_wdata <= c;
      @(posedge clock);
      csr_index <= CSR_USER_BASE;
      csr_wdata <= u;
      @(posedge clock);
      // unused index must be ignored
      csr_index <= CSR_UNUSED;
      csr_wdata <= ~s;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_strobe = s;
      cfg_chan = c;
      cfg_user = u;
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_STROBE_ADDR;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_NOP;
      req_chan.bus_addr = '0;
      req_chan.write_data = '0;
      req_chan.generator = '0;
      req_chan.event_level = 1'b0;
      hold_rsp = 1'b0;
      send_idle_pct = 10;
      rsp_idle_pct = 74;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // separate windows
      program_windows(16'h0040, 16'h0100, 16'h0200);
      push_request(mk_req(OP_WRITE, cfg_chan, 8'd1, 8'h00, 1'b0));
      push_request(mk_req(OP_WRITE, 16'(cfg_chan + 3), 8'd1, 8'h00, 1'b0));
      push_request(mk_req(OP_WRITE, 16'(cfg_chan + 7), 8'hFF, 8'h00, 1'b0));
      push_request(mk_req(OP_WRITE, cfg_user, 8'd1, 8'h00, 1'b0));
      push_request(mk_req(OP_WRITE, 16'(cfg_user + 15), 8'd8, 8'h00, 1'b0));
      push_request(mk_req(OP_WRITE, 16'(cfg_user + 5), 8'd4, 8'h00, 1'b0));
      // select off, one past the last channel, and far above it
      push_request(mk_req(OP_WRITE, 16'(cfg_user + 6), 8'd0, 8'h00, 1'b0));
      push_request(mk_req(OP_WRITE, 16'(cfg_user + 7), 8'd9, 8'h00, 1'b0));
      push_request(mk_req(OP_WRITE, 16'(cfg_user + 8), 8'hFF, 8'h00, 1'b0));
      push_request(mk_req(OP_EVENT, 16'h0000, 8'h00, 8'd1, 1'b1));
      push_request(mk_req(OP_EVENT, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
      // generator zero is ignored
      push_request(mk_req(OP_EVENT, 16'h0000, 8'h00, 8'd0, 1'b1));
      push_request(mk_req(OP_EVENT, 16'h0000, 8'h00, 8'd1, 1'b0));
      push_request(mk_req(OP_WRITE, cfg_strobe, 8'hFF, 8'h00, 1'b0));
      push_request(mk_req(OP_WRITE, cfg_strobe, 8'h80, 8'h00, 1'b0));
      push_request(mk_req(OP_WRITE, cfg_strobe, 8'h00, 8'h00, 1'b0));
      push_request(mk_req(OP_READ, cfg_strobe, 8'h00, 8'h00, 1'b0));
      push_request(mk_req(OP_READ, 16'(cfg_chan + 7), 8'h00, 8'h00, 1'b0));
      push_request(mk_req(OP_READ, 16'(cfg_user + 15), 8'h00, 8'h00, 1'b0));
      // unmapped read and write, then just past each window
      push_request(mk_req(OP_READ, 16'hFFFF, 8'h00, 8'h00, 1'b0));
      push_request(mk_req(OP_WRITE, 16'h0000, 8'hAA, 8'h00, 1'b0));
      push_request(mk_req(OP_NOP, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
      push_request(mk_req(OP_READ, 16'(cfg_user + 16), 8'h00, 8'h00, 1'b0));
      push_request(mk_req(OP_WRITE, 16'(cfg_chan + 8), 8'h55, 8'h00, 1'b0));
      push_random(480);
      drain();

      // strobe inside the channel window, channel window overlapping the user window
      send_idle_pct = 74;
      rsp_idle_pct = 10;
      program_windows(16'h8003, 16'h8000, 16'h7FFC);
      push_random(480);
      drain();

      // windows running into the top of the address space
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      program_windows(16'hFFFF, 16'hFFFA, 16'hFFF4);
      hold_rsp = 1'b1;
      push_random(30);
      drain();
      push_random(440);
      drain();

      // everything stacked at address zero
      program_windows(16'h0000, 16'h0000, 16'h0000);
      push_random(470);
      drain();
      repeat (5) @(posedge clock);

      if (fail_count == 0)
         $display("** event_routing_matrix_core: PASSED **");
      else
         $display("** event_routing_matrix_core: FAILED **");
      $finish;
   end

endmodule
